// ===== hw/rtl/csg_pkg.sv =====
package csg_pkg;

  // Largest modulus and the cap on results per generator
  localparam int unsigned ModulusMax = 64;

  localparam int unsigned ElemW   = 6;                          // element / generator width
  localparam int unsigned ModW    = 7;                          // modulus register width
  localparam int unsigned CountW  = $clog2(ModulusMax);         // results 0 .. ModulusMax-1
  localparam int unsigned StepW   = $clog2(ElemW + 1);          // serial step counter
  localparam int unsigned RedW    = ElemW + 2;                  // intermediate of the serial unit

  localparam logic [ModW-1:0]   ModulusMin   = ModW'(2);
  localparam logic [ModW-1:0]   ModulusLimit = ModW'(ModulusMax);
  localparam logic [ModW-1:0]   ModulusReset = ModW'(2);
  localparam logic [CountW-1:0] CountFinal   = CountW'(ModulusMax - 1);
  localparam logic [StepW-1:0]  StepCount    = StepW'(ElemW);

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_MUL = 1'b1
  } op_mode_e;

  typedef enum logic {
    REG_MODULUS = 1'b0,
    REG_MODE    = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_WAIT,
    ST_NEXT,
    ST_MUL_WAIT,
    ST_EMIT
  } csg_state_e;

  // Request to and response from the serial modular multiplier
  typedef struct packed {
    logic             start;
    logic [ElemW-1:0] a;
    logic [ElemW-1:0] b;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [ElemW-1:0] result;
  } mod_rsp_t;

endpackage

// ===== hw/rtl/csg_mod_mul.sv =====
// Bit-serial modular multiplier: result = (a * b) mod n, one bit of b per cycle, MSB first.
module csg_mod_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csg_pkg::mod_req_t             req_i,
  input  logic [csg_pkg::ModW-1:0]      modulus_i,
  output csg_pkg::mod_rsp_t             rsp_o
);

  localparam logic [csg_pkg::StepW-1:0] StepW1 = csg_pkg::StepW'(1);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [csg_pkg::StepW-1:0]     step_q, step_d;
  logic [csg_pkg::ElemW-1:0]     b_sh_q, b_sh_d;
  logic [csg_pkg::ElemW-1:0]     a_q, a_d;
  logic [csg_pkg::ElemW-1:0]     r_q, r_d;

  logic [csg_pkg::RedW-1:0]      n_ext;
  logic [csg_pkg::RedW-1:0]      dbl, dbl_red, acc, acc_red;

  // One step: r = (2r mod n + bit * a) mod n, each half a single compare-subtract
  always_comb begin
    n_ext   = {1'b0, modulus_i};
    dbl     = {1'b0, r_q, 1'b0};
    dbl_red = (dbl >= n_ext) ? (dbl - n_ext) : dbl;
    acc     = dbl_red + (b_sh_q[csg_pkg::ElemW-1] ? {2'b00, a_q} : '0);
    acc_red = (acc >= n_ext) ? (acc - n_ext) : acc;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    b_sh_d = b_sh_q;
    a_d    = a_q;
    r_d    = r_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      step_d = csg_pkg::StepCount;
      b_sh_d = req_i.b;
      a_d    = req_i.a;
      r_d    = '0;
    end else if (busy_q) begin
      r_d    = acc_red[csg_pkg::ElemW-1:0];
      b_sh_d = {b_sh_q[csg_pkg::ElemW-2:0], 1'b0};
      step_d = step_q - StepW1;
      if (step_q == StepW1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_sh_q <= b_sh_d;
    a_q    <= a_d;
    r_q    <= r_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = r_q;

  // Completion follows a run of the shift register
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("csg_mod_mul: done without a preceding run");

  // Result is always reduced below the modulus
  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ({1'b0, r_q} < modulus_i))
    else $error("csg_mod_mul: result not reduced");

  // Step counter stays within the operand width while running
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q != '0 && step_q <= csg_pkg::StepCount))
    else $error("csg_mod_mul: step counter out of range");

endmodule

// ===== hw/rtl/cyclic_subgroup_generator_unit.sv =====
// Cyclic subgroup generator for the integers modulo n. Pulse start_i while busy_o is low to
// hand over a generator; the block then lists its subgroup, identity first, one element per
// result_valid_o pulse, with last_o on the final element. no_return_o rises with last_o when a
// multiplicative generator fails to return to one within 64 results. The receiver cannot stall:
// each result is on the ports for exactly one cycle and must be taken then. The bit-serial modular
// multiplier, which takes one generator bit per cycle, first reduces the generator; after that it
// computes each next element in multiplicative mode, while additive mode adds the reduced
// generator with a compare-subtract. busy_o stays high from the accepted start until the final
// element has been presented. The user must write modulus and operation_mode over the APB
// port only while busy_o is low; the block itself does not enforce this.
module cyclic_subgroup_generator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // command
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [csg_pkg::ElemW-1:0]     generator_i,
  // results
  output logic                          result_valid_o,
  output logic [csg_pkg::ElemW-1:0]     element_o,
  output logic                          last_o,
  output logic                          no_return_o
);

  // ---------------------------------------------------------------- configuration registers
  logic [csg_pkg::ModW-1:0] modulus_q;
  csg_pkg::op_mode_e        mode_q;
  csg_pkg::reg_idx_e        wr_idx;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign wr_idx = csg_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= csg_pkg::ModulusReset;
      mode_q    <= csg_pkg::OP_ADD;
    end else if (cfg_wr) begin
      unique case (wr_idx)
        csg_pkg::REG_MODULUS: modulus_q <= pwdata[csg_pkg::ModW-1:0];
        csg_pkg::REG_MODE:    mode_q    <= csg_pkg::op_mode_e'(pwdata[0]);
        default:              ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      csg_pkg::REG_MODULUS: prdata = {{(32-csg_pkg::ModW){1'b0}}, modulus_q};
      csg_pkg::REG_MODE:    prdata = {31'b0, mode_q};
      default:              prdata = '0;
    endcase
  end

  // Clamp the modulus into 2 .. ModulusMax
  logic [csg_pkg::ModW-1:0]  n_eff;
  logic [csg_pkg::ElemW-1:0] identity;

  always_comb begin
    if (modulus_q < csg_pkg::ModulusMin) begin
      n_eff = csg_pkg::ModulusMin;
    end else if (modulus_q > csg_pkg::ModulusLimit) begin
      n_eff = csg_pkg::ModulusLimit;
    end else begin
      n_eff = modulus_q;
    end
  end

  assign identity = csg_pkg::ElemW'(mode_q);

  // ---------------------------------------------------------------- datapath registers
  csg_pkg::csg_state_e          state_q, state_d;
  logic [csg_pkg::ElemW-1:0]    gen_q, gen_d;        // generator as given
  logic [csg_pkg::ElemW-1:0]    gen_red_q, gen_red_d;// generator mod n
  logic [csg_pkg::ElemW-1:0]    run_q, run_d;        // running element
  logic [csg_pkg::ElemW-1:0]    next_q, next_d;      // element after run_q
  logic [csg_pkg::CountW-1:0]   count_q, count_d;    // results emitted so far

  csg_pkg::mod_req_t            mod_req;
  csg_pkg::mod_rsp_t            mod_rsp;

  csg_mod_mul u_mod_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mod_req),
    .modulus_i (n_eff),
    .rsp_o     (mod_rsp)
  );

  logic                         accept;
  logic [csg_pkg::ModW-1:0]     sum, sum_red;
  logic                         next_is_id;
  logic                         at_cap;
  logic                         is_last;

  assign accept     = start_i && (state_q == csg_pkg::ST_IDLE);
  assign sum        = {1'b0, run_q} + {1'b0, gen_red_q};
  assign sum_red    = (sum >= n_eff) ? (sum - n_eff) : sum;
  assign next_is_id = (next_q == identity);
  assign at_cap     = (count_q == csg_pkg::CountFinal);
  assign is_last    = next_is_id || at_cap;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csg_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = csg_pkg::ST_RED_WAIT;
        end
      end
      csg_pkg::ST_RED_WAIT: begin
        if (mod_rsp.done) begin
          state_d = csg_pkg::ST_NEXT;
        end
      end
      csg_pkg::ST_NEXT: begin
        state_d = (mode_q == csg_pkg::OP_MUL) ? csg_pkg::ST_MUL_WAIT : csg_pkg::ST_EMIT;
      end
      csg_pkg::ST_MUL_WAIT: begin
        if (mod_rsp.done) begin
          state_d = csg_pkg::ST_EMIT;
        end
      end
      csg_pkg::ST_EMIT: begin
        state_d = is_last ? csg_pkg::ST_IDLE : csg_pkg::ST_NEXT;
      end
      default: state_d = csg_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs and data updates
  always_comb begin
    gen_d       = gen_q;
    gen_red_d   = gen_red_q;
    run_d       = run_q;
    next_d      = next_q;
    count_d     = count_q;
    mod_req     = '{start: 1'b0, a: run_q, b: gen_q};
    unique case (state_q)
      csg_pkg::ST_IDLE: begin
        // reduce the generator: 1 * g mod n
        mod_req = '{start: accept, a: csg_pkg::ElemW'(1), b: generator_i};
        if (accept) begin
          gen_d   = generator_i;
          run_d   = identity;
          count_d = '0;
        end
      end
      csg_pkg::ST_RED_WAIT: begin
        if (mod_rsp.done) begin
          gen_red_d = mod_rsp.result;
        end
      end
      csg_pkg::ST_NEXT: begin
        if (mode_q == csg_pkg::OP_MUL) begin
          mod_req = '{start: 1'b1, a: run_q, b: gen_q};
        end else begin
          next_d = sum_red[csg_pkg::ElemW-1:0];
        end
      end
      csg_pkg::ST_MUL_WAIT: begin
        if (mod_rsp.done) begin
          next_d = mod_rsp.result;
        end
      end
      csg_pkg::ST_EMIT: begin
        // advance after presenting the current element
        run_d   = next_q;
        count_d = count_q + csg_pkg::CountW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    result_valid_o = (state_q == csg_pkg::ST_EMIT);
    busy_o         = (state_q != csg_pkg::ST_IDLE);
    element_o      = run_q;
    last_o         = result_valid_o && is_last;
    no_return_o    = result_valid_o && !next_is_id && at_cap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csg_pkg::ST_IDLE;
      count_q <= '0;
      run_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      run_q   <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gen_q     <= gen_d;
    gen_red_q <= gen_red_d;
    next_q    <= next_d;
  end

  // ---------------------------------------------------------------- assertions
  // A finished list returns the block to idle
  a_last_ends_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> !busy_o)
    else $error("cyclic_subgroup_generator_unit: still busy after last element");

  // A result that is not the last is followed by more work
  a_more_after_nonlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |=> busy_o)
    else $error("cyclic_subgroup_generator_unit: list dropped before last element");

  // The cap flag only appears in multiplicative mode
  a_no_return_mul_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    no_return_o |-> (last_o && mode_q == csg_pkg::OP_MUL))
    else $error("cyclic_subgroup_generator_unit: no_return outside multiplicative cap");

  // The serial unit only finishes while a reduction or multiplication is awaited
  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == csg_pkg::ST_RED_WAIT || state_q == csg_pkg::ST_MUL_WAIT))
    else $error("cyclic_subgroup_generator_unit: unexpected multiplier completion");

endmodule

// ===== verif/csg_subgroup_checker.sv =====
module csg_subgroup_checker
  import csg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [ElemW-1:0] generator_i,
  input  logic             result_valid_i,
  input  logic [ElemW-1:0] element_i,
  input  logic             last_i,
  input  logic             no_return_i,
  output int               mismatch_count_o,
  output int               pending_count_o
);

  typedef struct packed {
    logic [ElemW-1:0] element;
    logic             last;
    logic             no_return;
  } subgroup_elem_t;

  logic [ModW-1:0] cfg_modulus;
  op_mode_e        cfg_mode;
  subgroup_elem_t  expected_elements[$];

  task automatic log_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count_o++;
  endtask

  // Append the whole subgroup listing for one generator, identity first
  function automatic void list_subgroup(input logic [ElemW-1:0] gen);
    int unsigned    n;
    int unsigned    ident;
    int unsigned    cur;
    int unsigned    nxt;
    subgroup_elem_t e;
    n = cfg_modulus;
    if (n < ModulusMin) n = ModulusMin;
    if (n > ModulusMax) n = ModulusMax;
    ident = (cfg_mode == OP_MUL) ? 1 : 0;
    cur   = ident;
    for (int unsigned k = 0; k < ModulusMax; k++) begin
      nxt = (cfg_mode == OP_MUL) ? (cur * gen) % n : (cur + gen) % n;
      e.element   = ElemW'(cur);
      e.last      = (nxt == ident) || (k + 1 >= ModulusMax);
      e.no_return = (nxt != ident) && (k + 1 >= ModulusMax);
      expected_elements.push_back(e);
      if (e.last) break;
      cur = nxt;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    subgroup_elem_t want;
    if (!rst_ni) begin
      cfg_modulus      = ModulusReset;
      cfg_mode         = OP_ADD;
      mismatch_count_o = 0;
      expected_elements.delete();
      pending_count_o <= 0;
    end else begin
      // compare first, so a result never matches an item taken on the same edge
      if (result_valid_i) begin
        if (expected_elements.size() == 0) begin
          log_mismatch("unexpected element", element_i, -1);
        end else begin
          want = expected_elements.pop_front();
          if (element_i !== want.element) log_mismatch("element", element_i, want.element);
          if (last_i !== want.last) log_mismatch("last", last_i, want.last);
          if (no_return_i !== want.no_return)
            log_mismatch("no_return", no_return_i, want.no_return);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[2]))
          REG_MODULUS: cfg_modulus = pwdata[ModW-1:0];
          REG_MODE:    cfg_mode    = op_mode_e'(pwdata[0]);
          default: ;
        endcase
      end
      if (start_i && !busy_i) list_subgroup(generator_i);
      pending_count_o <= expected_elements.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
module tb;
  import csg_pkg::*;

  // Hang guard: far above the slowest legal run (every item 64 results in
  // multiplicative mode, plus the longest sender pauses)
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned ItemsPerPhase = 44;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  logic             start_i;
  logic             busy_o;
  logic [ElemW-1:0] generator_i;
  logic             result_valid_o;
  logic [ElemW-1:0] element_o;
  logic             last_o;
  logic             no_return_o;

  int               mismatches;
  int               pending;
  int unsigned      cycle_count;

  cyclic_subgroup_generator_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .generator_i    (generator_i),
    .result_valid_o (result_valid_o),
    .element_o      (element_o),
    .last_o         (last_o),
    .no_return_o    (no_return_o)
  );

  // Watch both channels and the register port, predict each listing, compare
  csg_subgroup_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .generator_i      (generator_i),
    .result_valid_i   (result_valid_o),
    .element_i        (element_o),
    .last_i           (last_o),
    .no_return_i      (no_return_o),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [ModW-1:0] modulus, input op_mode_e mode);
    write_reg(REG_MODULUS, 32'(modulus));
    write_reg(REG_MODE, 32'(mode));
  endtask

  // Drop start and hold off until every predicted element has come out
  task automatic drain_results();
    @(negedge clk_i) start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy_o);
    // every generator ends in a result, so a short settle is enough
    repeat (4) @(posedge clk_i);
  endtask

  // Offer one generator and wait for the transaction to be taken.
  // start stays high between back-to-back items; a pause lowers it first.
  task automatic send_item(input logic [ElemW-1:0] gen, input int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      @(negedge clk_i) start_i <= 1'b0;
      // now and then let the pause begin only once the block has gone idle
      if ($urandom_range(1) == 1) begin
        do @(posedge clk_i); while (busy_o);
      end
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i     <= 1'b1;
    generator_i <= gen;
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin
    int unsigned      idle_pct;
    int unsigned      pick;
    logic [ModW-1:0]  modulus;
    op_mode_e         mode;
    logic [31:0]      noise;

    cycle_count = 0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    start_i     = 1'b0;
    generator_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: defaults first, then clamped and in-range moduli in both modes
    send_item(ElemW'(1), 0);
    drain_results();
    set_config(ModW'(0), OP_ADD);            // below two, treated as two
    send_item(ElemW'(63), 0);
    send_item(ElemW'(1), 0);
    drain_results();
    set_config(ModulusLimit, OP_ADD);        // longest additive listing
    send_item(ElemW'(0), 0);
    send_item(ElemW'(1), 0);
    send_item(ElemW'(63), 0);
    send_item(ElemW'(42), 0);
    drain_results();
    set_config(ModW'(127), OP_MUL);          // above the cap, treated as 64
    send_item(ElemW'(1), 0);
    send_item(ElemW'(3), 0);
    send_item(ElemW'(2), 0);                 // never returns to one
    send_item(ElemW'(0), 0);
    send_item(ElemW'(63), 0);
    drain_results();
    set_config(ModW'(1), OP_MUL);
    send_item(ElemW'(1), 0);
    send_item(ElemW'(0), 0);
    send_item(ElemW'(63), 0);
    drain_results();
    set_config(ModW'(37), OP_MUL);
    send_item(ElemW'(40), 0);                // generator above the modulus
    send_item(ElemW'(2), 0);
    send_item(ElemW'(36), 0);
    drain_results();
    set_config(ModW'(2), OP_ADD);
    send_item(ElemW'(5), 0);
    send_item(ElemW'(2), 0);
    drain_results();
    set_config(ModW'(65), OP_ADD);
    send_item(ElemW'(21), 0);
    drain_results();

    // Random phases: new settings each time, sender idling varied per phase
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      pick = $urandom_range(9);
      if (pick == 0) modulus = ModW'($urandom_range(1));
      else if (pick == 1) modulus = ModW'($urandom_range(127, 65));
      else if (pick == 2) modulus = ModulusLimit;
      else modulus = ModW'($urandom_range(ModulusMax, 2));
      mode  = op_mode_e'($urandom_range(1));
      // spare upper bits of the data bus carry noise the registers must drop
      noise = $urandom();
      if ($urandom_range(1) == 1) begin
        write_reg(REG_MODE, {noise[31:1], mode});
        write_reg(REG_MODULUS, {noise[31:ModW], modulus});
      end else begin
        write_reg(REG_MODULUS, {noise[31:ModW], modulus});
        write_reg(REG_MODE, {noise[31:1], mode});
      end
      case (phase % 4)
        1:       idle_pct = 53;
        3:       idle_pct = 11;
        default: idle_pct = 0;
      endcase
      for (int unsigned i = 0; i < ItemsPerPhase; i++) begin
        // occasionally hold the sender until the block has emptied out
        if ($urandom_range(24) == 0) drain_results();
        send_item(ElemW'($urandom_range(63)), idle_pct);
      end
      drain_results();
    end

    // Catch any stray strobes after the last listing
    repeat (32) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
